FILE: design/iirc_pkg.sv
// shared types and constants of the clamped first-order iir filter
package iirc_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_CURRENT_INPUT   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_PREVIOUS_INPUT  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_PREVIOUS_OUTPUT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOWER_LIMIT          = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_LIMIT          = 3'd4;

   // reset values
   localparam logic signed [CSR_DATA_WIDTH-1:0] RST_GAIN_CURRENT_INPUT   = 32'sh0100_0000;
   localparam logic signed [CSR_DATA_WIDTH-1:0] RST_GAIN_PREVIOUS_INPUT  = 32'sh0000_0000;
   localparam logic signed [CSR_DATA_WIDTH-1:0] RST_GAIN_PREVIOUS_OUTPUT = 32'sh0000_0000;
   localparam logic signed [CSR_DATA_WIDTH-1:0] RST_LOWER_LIMIT          = 32'sh8000_0000;
   localparam logic signed [CSR_DATA_WIDTH-1:0] RST_UPPER_LIMIT          = 32'sh7fff_ffff;

   typedef struct packed {
      logic signed [CSR_DATA_WIDTH-1:0] gain_current_input;
      logic signed [CSR_DATA_WIDTH-1:0] gain_previous_input;
      logic signed [CSR_DATA_WIDTH-1:0] gain_previous_output;
      logic signed [CSR_DATA_WIDTH-1:0] lower_limit;
      logic signed [CSR_DATA_WIDTH-1:0] upper_limit;
   } cfg_type;

endpackage

FILE: design/iirc_datapath.sv
// one filter or preload step: three products, rounding, clamp and next delay values
module iirc_datapath #(
   parameter int SAMPLE_WIDTH   = 32,
   parameter int COEF_FRAC_BITS = 24
) (
   input  iirc_pkg::cfg_type               cfg,
   input  logic                            mode,
   input  logic signed [SAMPLE_WIDTH-1:0]  sample,
   input  logic signed [SAMPLE_WIDTH-1:0]  preload_output,
   input  logic signed [SAMPLE_WIDTH-1:0]  delayed_input,
   input  logic signed [SAMPLE_WIDTH-1:0]  delayed_output,
   output logic signed [SAMPLE_WIDTH-1:0]  result,
   output logic                            clamped,
   output logic signed [SAMPLE_WIDTH-1:0]  next_delayed_input,
   output logic signed [SAMPLE_WIDTH-1:0]  next_delayed_output
);
   import iirc_pkg::*;

   localparam int PROD_W = CSR_DATA_WIDTH + SAMPLE_WIDTH;
   localparam int ACC_W  = PROD_W + 2;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_b0;
   logic signed [PROD_W-1:0] prod_b1;
   logic signed [PROD_W-1:0] prod_a1;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  y_full;
   logic signed [ACC_W-1:0]  upper_ext;
   logic signed [ACC_W-1:0]  lower_ext;
   logic                     above_upper;
   logic                     below_lower;

   assign prod_b0 = cfg.gain_current_input   * sample;
   assign prod_b1 = cfg.gain_previous_input  * delayed_input;
   assign prod_a1 = cfg.gain_previous_output * delayed_output;

   assign acc    = ACC_W'(prod_b0) + ACC_W'(prod_b1) - ACC_W'(prod_a1) + ROUND_HALF;
   assign y_full = acc >>> COEF_FRAC_BITS;

   assign upper_ext   = ACC_W'(cfg.upper_limit);
   assign lower_ext   = ACC_W'(cfg.lower_limit);
   assign above_upper = y_full > upper_ext;
   assign below_lower = y_full < lower_ext;

   always_comb begin
      if (mode) begin
         result              = preload_output;
         clamped             = 1'b0;
         next_delayed_input  = sample;
         next_delayed_output = preload_output;
      end else if (above_upper) begin
         result              = SAMPLE_WIDTH'(cfg.upper_limit);
         clamped             = 1'b1;
         next_delayed_input  = SAMPLE_WIDTH'(cfg.upper_limit);
         next_delayed_output = SAMPLE_WIDTH'(cfg.upper_limit);
      end else if (below_lower) begin
         result              = SAMPLE_WIDTH'(cfg.lower_limit);
         clamped             = 1'b1;
         next_delayed_input  = SAMPLE_WIDTH'(cfg.lower_limit);
         next_delayed_output = SAMPLE_WIDTH'(cfg.lower_limit);
      end else begin
         result              = y_full[SAMPLE_WIDTH-1:0];
         clamped             = 1'b0;
         next_delayed_input  = sample;
         next_delayed_output = y_full[SAMPLE_WIDTH-1:0];
      end
   end

endmodule

FILE: design/first_order_iir_clamped.sv
// top level of the clamped first-order iir filter with anti-windup
// path: an accepted transaction is registered in the input register and then in the result
// register that drives rsp_; a stall on rsp_ can hold it in the input register
// throughput: one transaction per cycle while rsp_stall does not hold the result register;
// delay registers loop through three parallel multipliers, rounding adder and clamp compare
// reset: clears input and result valids, zeroes both delays, restores register defaults
module first_order_iir_clamped #(
   parameter int SAMPLE_WIDTH   = 32,
   parameter int COEF_FRAC_BITS = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_mode,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_sample,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_preload_output,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_output_value,
   output logic                                    rsp_clamped,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [iirc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [iirc_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   import iirc_pkg::*;

   cfg_type                        cfg_ff;
   cfg_type                        cfg_in;

   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic                           in_mode_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_preload_ff;

   logic signed [SAMPLE_WIDTH-1:0] delayed_input_ff;
   logic signed [SAMPLE_WIDTH-1:0] delayed_output_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_value_ff;
   logic                           rsp_clamped_ff;

   logic signed [SAMPLE_WIDTH-1:0] step_result;
   logic                           step_clamped;
   logic signed [SAMPLE_WIDTH-1:0] step_delayed_input;
   logic signed [SAMPLE_WIDTH-1:0] step_delayed_output;
   logic                           load_rsp;

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAIN_CURRENT_INPUT:   cfg_in.gain_current_input   = csr_data;
            CSR_GAIN_PREVIOUS_INPUT:  cfg_in.gain_previous_input  = csr_data;
            CSR_GAIN_PREVIOUS_OUTPUT: cfg_in.gain_previous_output = csr_data;
            CSR_LOWER_LIMIT:          cfg_in.lower_limit          = csr_data;
            CSR_UPPER_LIMIT:          cfg_in.upper_limit          = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_current_input   <= RST_GAIN_CURRENT_INPUT;
         cfg_ff.gain_previous_input  <= RST_GAIN_PREVIOUS_INPUT;
         cfg_ff.gain_previous_output <= RST_GAIN_PREVIOUS_OUTPUT;
         cfg_ff.lower_limit          <= RST_LOWER_LIMIT;
         cfg_ff.upper_limit          <= RST_UPPER_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // flow control
   assign load_rsp     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_mode_ff    <= req_mode;
         in_sample_ff  <= req_sample;
         in_preload_ff <= req_preload_output;
      end
   end

   iirc_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .cfg                 (cfg_ff),
      .mode                (in_mode_ff),
      .sample              (in_sample_ff),
      .preload_output      (in_preload_ff),
      .delayed_input       (delayed_input_ff),
      .delayed_output      (delayed_output_ff),
      .result              (step_result),
      .clamped             (step_clamped),
      .next_delayed_input  (step_delayed_input),
      .next_delayed_output (step_delayed_output)
   );

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         delayed_input_ff  <= '0;
         delayed_output_ff <= '0;
      end else if (load_rsp) begin
         delayed_input_ff  <= step_delayed_input;
         delayed_output_ff <= step_delayed_output;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_value_ff   <= step_result;
         rsp_clamped_ff <= step_clamped;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_output_value = rsp_value_ff;
   assign rsp_clamped      = rsp_clamped_ff;

   // anti-windup leaves both delays at the limit that was output
   assert property (@(posedge clock) disable iff (reset)
      load_rsp && step_clamped |=>
         delayed_input_ff == delayed_output_ff && delayed_output_ff == rsp_value_ff)
      else $error("clamped step did not load both delays with the limit");

   // preload is never reported as clamped
   assert property (@(posedge clock) disable iff (reset)
      load_rsp && in_mode_ff |=> !rsp_clamped_ff)
      else $error("preload transaction reported as clamped");

   // the delayed output always tracks the last result produced
   assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> delayed_output_ff == rsp_value_ff)
      else $error("delayed output differs from last result");

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the clamped first-order iir filter
`timescale 1ns / 100ps

module testbench;
   import iirc_pkg::*;

   localparam int SAMPLE_WIDTH   = 32;
   localparam int COEF_FRAC_BITS = 24;
   localparam int HOLD_CYCLES    = 300;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int BLOCK_ITEMS    = 105;
   localparam logic signed [79:0] ROUND_HALF = 80'sd8388608;

   typedef enum logic {
      MODE_FILTER  = 1'b0,
      MODE_PRELOAD = 1'b1
   } iir_mode_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] value;
      logic                           clamped;
   } iir_result_type;

   typedef struct packed {
      iir_mode_type mode;
      logic [31:0]  sample;
      logic [31:0]  preload;
      logic [2:0]   setting;
      logic         typed;
      logic [31:0]  value;
      logic         clamped;
   } stimulus_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_mode = MODE_FILTER;
   logic signed [SAMPLE_WIDTH-1:0] req_sample = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_preload_output = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_output_value;
   logic                           rsp_clamped;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]      csr_data = '0;

   cfg_type                        settings = '{RST_GAIN_CURRENT_INPUT, RST_GAIN_PREVIOUS_INPUT,
                                                RST_GAIN_PREVIOUS_OUTPUT, RST_LOWER_LIMIT,
                                                RST_UPPER_LIMIT};
   logic signed [SAMPLE_WIDTH-1:0] prev_input = '0;
   logic signed [SAMPLE_WIDTH-1:0] prev_output = '0;
   iir_result_type                 pending_outputs [$];
   int                             failures = 0;
   int                             cycle_count = 0;
   int                             gap_pct = 0;
   int                             stall_pct = 0;
   bit                             hold_request = 1'b0;

   cfg_type directed_settings [0:4] = '{
      '{RST_GAIN_CURRENT_INPUT, RST_GAIN_PREVIOUS_INPUT, RST_GAIN_PREVIOUS_OUTPUT,
        RST_LOWER_LIMIT, RST_UPPER_LIMIT},
      '{32'sh0080_0000, 32'sh0, 32'sh0, 32'shfffb_0000, 32'sh0005_0000},
      '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff},
      '{32'sh0100_0000, 32'sh0, 32'sh0, 32'sh000a_0000, 32'shfff6_0000},
      '{32'sh0080_0000, 32'sh0080_0000, 32'shff19_999a, 32'shffff_0000, 32'sh0001_0000}
   };

   stimulus_row_type directed_rows [0:25] = '{
      '{MODE_FILTER,  32'h0000_0000, 32'h0000_0000, 3'd0, 1'b1, 32'h0000_0000, 1'b0},
      '{MODE_FILTER,  32'h7fff_ffff, 32'h0000_0000, 3'd0, 1'b1, 32'h7fff_ffff, 1'b0},
      '{MODE_FILTER,  32'h8000_0000, 32'h0000_0000, 3'd0, 1'b1, 32'h8000_0000, 1'b0},
      '{MODE_PRELOAD, 32'h1234_5678, 32'h8000_0000, 3'd0, 1'b1, 32'h8000_0000, 1'b0},
      '{MODE_PRELOAD, 32'h8000_0000, 32'h7fff_ffff, 3'd0, 1'b1, 32'h7fff_ffff, 1'b0},
      '{MODE_FILTER,  32'h0001_8000, 32'hffff_ffff, 3'd0, 1'b1, 32'h0001_8000, 1'b0},
      // half-lsb ties go up
      '{MODE_FILTER,  32'h0000_0001, 32'h0000_0000, 3'd1, 1'b1, 32'h0000_0001, 1'b0},
      '{MODE_FILTER,  32'hffff_ffff, 32'h0000_0000, 3'd1, 1'b1, 32'h0000_0000, 1'b0},
      '{MODE_FILTER,  32'h0000_0003, 32'h0000_0000, 3'd1, 1'b1, 32'h0000_0002, 1'b0},
      '{MODE_FILTER,  32'hffff_fffd, 32'h0000_0000, 3'd1, 1'b1, 32'hffff_ffff, 1'b0},
      '{MODE_FILTER,  32'h7fff_ffff, 32'h0000_0000, 3'd1, 1'b1, 32'h0005_0000, 1'b1},
      '{MODE_FILTER,  32'h8000_0000, 32'h0000_0000, 3'd1, 1'b1, 32'hfffb_0000, 1'b1},
      // preload value outside the limits is passed unclamped
      '{MODE_PRELOAD, 32'h0064_0000, 32'hff9c_0000, 3'd1, 1'b1, 32'hff9c_0000, 1'b0},
      '{MODE_PRELOAD, 32'h7fff_ffff, 32'h8000_0000, 3'd2, 1'b0, 32'h0, 1'b0},
      '{MODE_FILTER,  32'h8000_0000, 32'h0000_0000, 3'd2, 1'b0, 32'h0, 1'b0},
      '{MODE_PRELOAD, 32'h8000_0000, 32'h7fff_ffff, 3'd2, 1'b0, 32'h0, 1'b0},
      '{MODE_FILTER,  32'h7fff_ffff, 32'h0000_0000, 3'd2, 1'b0, 32'h0, 1'b0},
      '{MODE_FILTER,  32'h0000_0000, 32'h0000_0000, 3'd2, 1'b0, 32'h0, 1'b0},
      // crossed limits, upper test wins
      '{MODE_FILTER,  32'h0000_0000, 32'h0000_0000, 3'd3, 1'b1, 32'hfff6_0000, 1'b1},
      '{MODE_FILTER,  32'hffec_0000, 32'h0000_0000, 3'd3, 1'b1, 32'h000a_0000, 1'b1},
      '{MODE_FILTER,  32'hfff6_0000, 32'h0000_0000, 3'd3, 1'b1, 32'h000a_0000, 1'b1},
      // anti-windup with feedback
      '{MODE_FILTER,  32'h0005_0000, 32'h0000_0000, 3'd4, 1'b0, 32'h0, 1'b0},
      '{MODE_FILTER,  32'h0005_0000, 32'h0000_0000, 3'd4, 1'b0, 32'h0, 1'b0},
      '{MODE_FILTER,  32'hfffb_0000, 32'h0000_0000, 3'd4, 1'b0, 32'h0, 1'b0},
      '{MODE_PRELOAD, 32'h0000_8000, 32'h0000_4000, 3'd4, 1'b0, 32'h0, 1'b0},
      '{MODE_FILTER,  32'h0000_2000, 32'h0000_0000, 3'd4, 1'b0, 32'h0, 1'b0}
   };

   first_order_iir_clamped dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_sample         (req_sample),
      .req_preload_output (req_preload_output),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_output_value   (rsp_output_value),
      .rsp_clamped        (rsp_clamped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic iir_result_type iir_step(input iir_mode_type mode,
                                               input logic signed [31:0] sample,
                                               input logic signed [31:0] preload);
      logic signed [79:0] b0, b1, a1, u, up, yp, acc, y, lo_w, hi_w;
      iir_result_type     r;
      r.clamped = 1'b0;
      if (mode == MODE_PRELOAD) begin
         prev_input  = sample;
         prev_output = preload;
         r.value     = preload;
         return r;
      end
      b0   = $signed(settings.gain_current_input);
      b1   = $signed(settings.gain_previous_input);
      a1   = $signed(settings.gain_previous_output);
      lo_w = $signed(settings.lower_limit);
      hi_w = $signed(settings.upper_limit);
      u    = sample;
      up   = prev_input;
      yp   = prev_output;
      acc  = b0 * u + b1 * up - a1 * yp + ROUND_HALF;
      y    = acc >>> COEF_FRAC_BITS;
      if (y > hi_w) begin
         r.value   = settings.upper_limit;
         r.clamped = 1'b1;
      end else if (y < lo_w) begin
         r.value   = settings.lower_limit;
         r.clamped = 1'b1;
      end else begin
         r.value = y[31:0];
      end
      prev_input  = r.clamped ? r.value : sample;
      prev_output = r.value;
      return r;
   endfunction

   function automatic logic [31:0] random_sample();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'hffff_ffff;
               default: return 32'h0;
            endcase
         end
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   function automatic logic [31:0] random_gain();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0100_0000;
               default: return 32'h0;
            endcase
         end
         default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type     cfg;
      logic [31:0] span;
      cfg.gain_current_input   = random_gain();
      cfg.gain_previous_input  = random_gain();
      cfg.gain_previous_output = random_gain();
      span = $urandom_range(0, 32'h0010_0000);
      case ($urandom_range(0, 3))
         0: begin
            cfg.lower_limit = RST_LOWER_LIMIT;
            cfg.upper_limit = RST_UPPER_LIMIT;
         end
         1: begin
            cfg.lower_limit = -span;
            cfg.upper_limit = span;
         end
         2: begin
            cfg.lower_limit = span;
            cfg.upper_limit = -span;
         end
         default: begin
            cfg.lower_limit = $urandom;
            cfg.upper_limit = $urandom;
         end
      endcase
      return cfg;
   endfunction

   task automatic offer_sample(input iir_mode_type mode, input logic [31:0] sample,
                               input logic [31:0] preload, input bit typed,
                               input iir_result_type typed_result);
      iir_result_type predicted;
      // sender idles cycle by cycle before offering
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_sample         <= sample;
      req_preload_output <= preload;
      do @(posedge clock); while (req_stall);
      predicted = iir_step(mode, sample, preload);
      pending_outputs.push_back(typed ? typed_result : predicted);
   endtask

   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input cfg_type cfg);
      logic [CSR_INDEX_WIDTH-1:0] indexes [0:4];
      logic [CSR_DATA_WIDTH-1:0]  values [0:4];
      indexes[0] = CSR_GAIN_CURRENT_INPUT;
      indexes[1] = CSR_GAIN_PREVIOUS_INPUT;
      indexes[2] = CSR_GAIN_PREVIOUS_OUTPUT;
      indexes[3] = CSR_LOWER_LIMIT;
      indexes[4] = CSR_UPPER_LIMIT;
      values[0]  = cfg.gain_current_input;
      values[1]  = cfg.gain_previous_input;
      values[2]  = cfg.gain_previous_output;
      values[3]  = cfg.lower_limit;
      values[4]  = cfg.upper_limit;
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= indexes[i];
         csr_data  <= values[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings = cfg;
   endtask

   // receiver side: random stall, or a long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      iir_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outputs.size() == 0) begin
            $error("unexpected result transaction: output_value %h clamped %b",
                   rsp_output_value, rsp_clamped);
            failures++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_output_value !== want.value) begin
               $error("output_value expected %h got %h", want.value, rsp_output_value);
               failures++;
            end
            if (rsp_clamped !== want.clamped) begin
               $error("clamped expected %b got %b", want.clamped, rsp_clamped);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int             current;
      iir_result_type typed_result;
      current = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_pct   = 14;
      stall_pct = 47;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].setting != current) begin
            current = directed_rows[i].setting;
            settle_pipeline();
            write_settings(directed_settings[current]);
         end
         typed_result.value   = directed_rows[i].value;
         typed_result.clamped = directed_rows[i].clamped;
         offer_sample(directed_rows[i].mode, directed_rows[i].sample,
                      directed_rows[i].preload, directed_rows[i].typed, typed_result);
      end

      typed_result = '0;
      for (int phase = 0; phase < 3; phase++) begin
         gap_pct   = (phase == 0) ? 14 : (phase == 1) ? 47 : 0;
         stall_pct = (phase == 0) ? 47 : (phase == 1) ? 14 : 0;
         for (int blk = 0; blk < 4; blk++) begin
            settle_pipeline();
            write_settings(random_settings());
            if (phase == 2 && blk == 0) hold_request = 1'b1;
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
               offer_sample(($urandom_range(0, 99) < 8) ? MODE_PRELOAD : MODE_FILTER,
                            random_sample(), random_sample(), 1'b0, typed_result);
            end
         end
      end

      settle_pipeline();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
